[design/tct_pkg.sv]
// Package with the shared types and command codes of the touch contact table.
`default_nettype none
package tct_pkg;

  localparam logic [1:0] CMD_DOWN   = 2'd0;
  localparam logic [1:0] CMD_MOVE   = 2'd1;
  localparam logic [1:0] CMD_UP     = 2'd2;
  localparam logic [1:0] CMD_CANCEL = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] touch_id;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
  } tct_in_t;

  typedef struct packed {
    logic        forwarded;
    logic [3:0]  slot;
    logic [15:0] start_x;
    logic [15:0] start_y;
    logic [4:0]  active_count;
  } tct_out_t;

  typedef struct packed {
    logic [31:0] id;
    logic [15:0] cur_x;
    logic [15:0] cur_y;
    logic [15:0] init_x;
    logic [15:0] init_y;
  } tct_entry_t;

  typedef struct packed {
    logic load;
    logic move;
    logic shift;
  } tct_cell_ctl_t;

endpackage
`default_nettype wire

[design/tct_cell.sv]
// One table cell: holds a contact entry, loads or moves it, compares its id and takes its neighbor's entry.
`default_nettype none
module tct_cell (
  input  wire                    clk,
  input  tct_pkg::tct_in_t       key,
  input  wire                    valid,
  input  tct_pkg::tct_cell_ctl_t ctl,
  input  tct_pkg::tct_entry_t    nbr,
  output tct_pkg::tct_entry_t    entry,
  output logic                   hit
);
  import tct_pkg::*;

  assign hit = valid && (entry.id == key.touch_id);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      entry <= '{id: key.touch_id, cur_x: key.pos_x, cur_y: key.pos_y,
                 init_x: key.pos_x, init_y: key.pos_y};
    end else if (ctl.move) begin
      entry.cur_x <= key.pos_x;
      entry.cur_y <= key.pos_y;
    end else if (ctl.shift) begin
      entry <= nbr;
    end
  end

endmodule
`default_nettype wire

[design/touch_contact_table_unit.sv]
// Top level of the touch contact table: input stage, row of contact cells, result register.
// An accepted transaction waits in the input stage until the result register is free; its result is then registered.
// No new transaction is accepted while one is pending; the cell row is updated as the result is registered.
// An input transaction may be accepted while the previous result still waits on the output.
// Reset clears the contact count and the handshake state; cell contents are not cleared.
`default_nettype none
module touch_contact_table_unit #(
  parameter int MAX_CONTACTS = 16
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_stall,
  input  tct_pkg::tct_in_t   in_data,
  output logic               out_valid,
  input  wire                out_stall,
  output tct_pkg::tct_out_t  out_data
);
  import tct_pkg::*;

  localparam int CW = $clog2(MAX_CONTACTS + 1);
  localparam int IW = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;

  tct_in_t                    key;
  logic                       pend;
  logic [CW-1:0]              count;
  logic [CW-1:0]              count_next;
  logic                       exec;
  tct_entry_t                 entries [MAX_CONTACTS];
  tct_cell_ctl_t              ctl [MAX_CONTACTS];
  logic [MAX_CONTACTS-1:0]    hit;
  logic [MAX_CONTACTS-1:0]    first;
  logic [MAX_CONTACTS-1:0]    after;
  logic                       found;
  logic                       full;
  logic [IW-1:0]              hit_idx;
  logic [15:0]                hit_sx;
  logic [15:0]                hit_sy;
  tct_out_t                   res;

  assign in_stall = pend;
  assign exec     = pend && (!out_valid || !out_stall);
  assign full     = (count == CW'(MAX_CONTACTS));

  always_comb begin
    logic any_lower;
    any_lower = 1'b0;
    hit_idx   = '0;
    hit_sx    = '0;
    hit_sy    = '0;
    for (int i = 0; i < MAX_CONTACTS; i++) begin
      first[i]  = hit[i] && !any_lower;
      after[i]  = hit[i] || any_lower;
      any_lower = any_lower || hit[i];
      if (first[i]) begin
        hit_idx = hit_idx | IW'(i);
        hit_sx  = hit_sx | entries[i].init_x;
        hit_sy  = hit_sy | entries[i].init_y;
      end
    end
    found = any_lower;
  end

  always_comb begin
    count_next = count;
    res        = '0;
    for (int i = 0; i < MAX_CONTACTS; i++) begin
      ctl[i] = '0;
    end
    if (key.command == CMD_DOWN) begin
      if (!full) begin
        count_next    = count + CW'(1);
        res.forwarded = 1'b1;
        res.slot      = 4'(count);
        res.start_x   = key.pos_x;
        res.start_y   = key.pos_y;
        for (int i = 0; i < MAX_CONTACTS; i++) begin
          ctl[i].load = exec && (count == CW'(i));
        end
      end
    end else if (found) begin
      res.forwarded = 1'b1;
      res.slot      = 4'(hit_idx);
      res.start_x   = hit_sx;
      res.start_y   = hit_sy;
      if (key.command == CMD_MOVE) begin
        for (int i = 0; i < MAX_CONTACTS; i++) begin
          ctl[i].move = exec && first[i];
        end
      end else begin
        count_next = count - CW'(1);
        for (int i = 0; i < MAX_CONTACTS; i++) begin
          ctl[i].shift = exec && after[i];
        end
      end
    end
    res.active_count = 5'(count_next);
  end

  for (genvar g = 0; g < MAX_CONTACTS; g++) begin : g_cell
    tct_cell u_cell (
      .clk   (clk),
      .key   (key),
      .valid (CW'(g) < count),
      .ctl   (ctl[g]),
      .nbr   (entries[(g + 1 < MAX_CONTACTS) ? g + 1 : g]),
      .entry (entries[g]),
      .hit   (hit[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        pend <= 1'b1;
      end else if (exec) begin
        pend <= 1'b0;
      end
      if (exec) begin
        out_valid <= 1'b1;
        count     <= count_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      key <= in_data;
    end
    if (exec) begin
      out_data <= res;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_CONTACTS))
    else $error("contact count exceeds table size");

  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.forwarded) |->
      (out_data.slot == 4'd0 && out_data.start_x == 16'd0 && out_data.start_y == 16'd0))
    else $error("dropped transaction carries nonzero fields");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accepting a transaction");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !exec |=> (count == $past(count)))
    else $error("contact count changed without a transaction");
`endif

endmodule
`default_nettype wire
